[rtl/core/rme_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, constants and helpers for the roman numeral encoder.
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int unsigned VALUE_W = 14;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned REM_W   = 12;   // magnitude after range check, at most 3999
  localparam int unsigned PLACE_W = 2;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned K_W     = 2;    // position inside one digit's symbols
  localparam int unsigned LEN_W   = 3;

  localparam logic [VALUE_W-1:0] MAX_MAG   = VALUE_W'(3999);
  localparam logic [PLACE_W-1:0] TOP_PLACE = PLACE_W'(3);

  // symbol roles inside one decimal place
  localparam logic [1:0] ROLE_UNIT = 2'd0;
  localparam logic [1:0] ROLE_FIVE = 2'd1;
  localparam logic [1:0] ROLE_TEN  = 2'd2;

  localparam logic [SYM_W-1:0] SYM_NONE = 8'h00;

  localparam logic [SYM_W-1:0] UNIT_SYM [4] = '{8'h49, 8'h58, 8'h43, 8'h4D}; // I X C M
  localparam logic [SYM_W-1:0] FIVE_SYM [4] = '{8'h56, 8'h4C, 8'h44, 8'h00}; // V L D
  localparam logic [SYM_W-1:0] TEN_SYM  [4] = '{8'h58, 8'h43, 8'h4D, 8'h00}; // X C M

  // d times the place weight, for d = 0 to 9
  localparam logic [VALUE_W-1:0] STEP_TAB [4][10] = '{
    '{14'd0, 14'd1,    14'd2,    14'd3,    14'd4,    14'd5,    14'd6,    14'd7,
      14'd8, 14'd9},
    '{14'd0, 14'd10,   14'd20,   14'd30,   14'd40,   14'd50,   14'd60,   14'd70,
      14'd80, 14'd90},
    '{14'd0, 14'd100,  14'd200,  14'd300,  14'd400,  14'd500,  14'd600,  14'd700,
      14'd800, 14'd900},
    '{14'd0, 14'd1000, 14'd2000, 14'd3000, 14'd4000, 14'd5000, 14'd6000, 14'd7000,
      14'd8000, 14'd9000}
  };

  // controller to datapath
  typedef struct packed {
    logic load;        // take a new input value
    logic take_digit;  // latch the digit of the current place and strip it
    logic skip_place;  // current digit is zero, move to next place
    logic emit_sym;    // load one symbol into the output register
    logic emit_err;    // load the out of range result
  } rme_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic oor;         // magnitude above 3999
    logic rem_zero;    // nothing left to encode
    logic digit_zero;  // digit of the current place is zero
    logic sym_final;   // current symbol is the last of its digit
  } rme_sts_t;

  // digit of the remainder at a place, by comparison against the step table
  function automatic logic [DIGIT_W-1:0] digit_of(input logic [REM_W-1:0] rem,
                                                  input logic [PLACE_W-1:0] place);
    logic [DIGIT_W-1:0] dig;
    dig = '0;
    for (int d = 1; d < 10; d++) begin
      if ({{(VALUE_W-REM_W){1'b0}}, rem} >= STEP_TAB[place][d]) begin
        dig = DIGIT_W'(d);
      end
    end
    return dig;
  endfunction

  // number of symbols a digit produces
  function automatic logic [LEN_W-1:0] digit_len(input logic [DIGIT_W-1:0] dig);
    logic [LEN_W-1:0] len;
    if (dig <= DIGIT_W'(3)) begin
      len = dig[LEN_W-1:0];
    end else if (dig == DIGIT_W'(4) || dig == DIGIT_W'(9)) begin
      len = LEN_W'(2);
    end else begin
      len = LEN_W'(dig - DIGIT_W'(4));
    end
    return len;
  endfunction

  // role of the symbol at position k of a digit
  function automatic logic [1:0] sym_role(input logic [DIGIT_W-1:0] dig,
                                          input logic [K_W-1:0] k);
    logic [1:0] role;
    role = ROLE_UNIT;
    if (dig == DIGIT_W'(4)) begin
      role = (k == '0) ? ROLE_UNIT : ROLE_FIVE;
    end else if (dig == DIGIT_W'(9)) begin
      role = (k == '0) ? ROLE_UNIT : ROLE_TEN;
    end else if (dig >= DIGIT_W'(5)) begin
      role = (k == '0) ? ROLE_FIVE : ROLE_UNIT;
    end
    return role;
  endfunction

endpackage

[rtl/core/roman_numeral_encoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder
// Turns a signed integer into the Roman numeral of its magnitude, one ASCII
// character per output transaction, thousands first, last character flagged.
// ----------------------------------------------------------------------------
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  input   | in_valid, in_ready, in_value[13:0]           | in
//  output  | out_valid, out_ready, out_symbol[7:0],       | out
//          | out_last, out_out_of_range                   |
//
//  One input transaction at a time: after the accept, the places are scanned from
//  the thousands down and each nonzero digit emits its characters, until nothing is left.
//  The character sequencer in rme_ctrl sets this order; a new value is taken
//  once the previous one is fully sequenced.
//  A stalled output register holds the sequencer in place.
//  Reset (synchronous, active low) clears the sequencer and the output valid.
//  A zero magnitude gives no output; above 3999 gives one flagged transaction.
// ----------------------------------------------------------------------------
module roman_numeral_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rme_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rme_pkg::SYM_W-1:0]   out_symbol,
  output logic                        out_last,
  output logic                        out_out_of_range
);
  import rme_pkg::*;

  rme_cmd_t cmd;
  rme_sts_t sts;

  // sequencer
  rme_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // digit and symbol datapath
  rme_datapath u_dp (
    .clk              (clk),
    .in_value         (in_value),
    .cmd              (cmd),
    .sts              (sts),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

endmodule

[rtl/core/rme_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_datapath
// Magnitude, remainder, digit and output registers of the encoder.
// ----------------------------------------------------------------------------
module rme_datapath (
  input  logic                        clk,
  input  logic [rme_pkg::VALUE_W-1:0] in_value,
  input  rme_pkg::rme_cmd_t           cmd,
  output rme_pkg::rme_sts_t           sts,
  output logic [rme_pkg::SYM_W-1:0]   out_symbol,
  output logic                        out_last,
  output logic                        out_out_of_range
);
  import rme_pkg::*;

  logic [REM_W-1:0]   rem_r,   rem_nxt;
  logic [PLACE_W-1:0] place_r, place_nxt;
  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic [K_W-1:0]     k_r,     k_nxt;
  logic               oor_r,   oor_nxt;
  logic [SYM_W-1:0]   sym_r,   sym_nxt;
  logic               last_r,  last_nxt;
  logic               eoor_r,  eoor_nxt;

  logic [VALUE_W-1:0] mag;
  logic [DIGIT_W-1:0] digit_c;
  logic [VALUE_W-1:0] rem_diff;
  logic [LEN_W-1:0]   len_c;
  logic               sym_final;
  logic [SYM_W-1:0]   sym_c;

  // magnitude of the two's complement input
  assign mag = in_value[VALUE_W-1] ? (~in_value + VALUE_W'(1)) : in_value;

  // digit of the current place and what remains without it
  assign digit_c  = digit_of(rem_r, place_r);
  assign rem_diff = {{(VALUE_W-REM_W){1'b0}}, rem_r} - STEP_TAB[place_r][digit_c];

  // symbol selection inside the latched digit
  assign len_c     = digit_len(digit_r);
  assign sym_final = ({1'b0, k_r} == (len_c - LEN_W'(1)));

  always_comb begin
    unique case (sym_role(digit_r, k_r))
      ROLE_UNIT: sym_c = UNIT_SYM[place_r];
      ROLE_FIVE: sym_c = FIVE_SYM[place_r];
      ROLE_TEN:  sym_c = TEN_SYM[place_r];
      default:   sym_c = SYM_NONE;
    endcase
  end

  // next state of the working registers
  always_comb begin
    rem_nxt   = rem_r;
    place_nxt = place_r;
    digit_nxt = digit_r;
    k_nxt     = k_r;
    oor_nxt   = oor_r;
    sym_nxt   = sym_r;
    last_nxt  = last_r;
    eoor_nxt  = eoor_r;
    if (cmd.load) begin
      rem_nxt   = mag[REM_W-1:0];
      place_nxt = TOP_PLACE;
      oor_nxt   = (mag > MAX_MAG);
    end
    if (cmd.take_digit) begin
      digit_nxt = digit_c;
      rem_nxt   = rem_diff[REM_W-1:0];
      k_nxt     = '0;
    end
    if (cmd.skip_place) begin
      place_nxt = place_r - PLACE_W'(1);
    end
    if (cmd.emit_sym) begin
      sym_nxt  = sym_c;
      last_nxt = sym_final && (rem_r == '0);
      eoor_nxt = 1'b0;
      if (sym_final) begin
        place_nxt = place_r - PLACE_W'(1);
      end else begin
        k_nxt = k_r + K_W'(1);
      end
    end
    if (cmd.emit_err) begin
      sym_nxt  = SYM_NONE;
      last_nxt = 1'b1;
      eoor_nxt = 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    place_r <= place_nxt;
    digit_r <= digit_nxt;
    k_r     <= k_nxt;
    oor_r   <= oor_nxt;
    sym_r   <= sym_nxt;
    last_r  <= last_nxt;
    eoor_r  <= eoor_nxt;
  end

  // status back to the controller
  assign sts.oor        = oor_r;
  assign sts.rem_zero   = (rem_r == '0);
  assign sts.digit_zero = (digit_c == '0);
  assign sts.sym_final  = sym_final;

  assign out_symbol       = sym_r;
  assign out_last         = last_r;
  assign out_out_of_range = eoor_r;

endmodule

[rtl/core/rme_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_ctrl
// Sequencer of the encoder: walks the places and meters out the symbols.
// ----------------------------------------------------------------------------
module rme_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rme_pkg::rme_sts_t sts,
  output rme_pkg::rme_cmd_t cmd
);
  import rme_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIGIT = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;
  localparam logic [1:0] ST_ERR   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       ovld_r,  ovld_nxt;
  logic       out_free;

  // output register can take a new symbol
  assign out_free = !ovld_r || out_ready;
  assign in_ready = (state_r == ST_IDLE);

  // state transitions and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        priority if (sts.oor) begin
          state_nxt = ST_ERR;
        end else if (sts.rem_zero) begin
          state_nxt = ST_IDLE;
        end else if (sts.digit_zero) begin
          cmd.skip_place = 1'b1;
        end else begin
          cmd.take_digit = 1'b1;
          state_nxt      = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit_sym = 1'b1;
          if (sts.sym_final) begin
            state_nxt = ST_DIGIT;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.emit_sym || cmd.emit_err) begin
      ovld_nxt = 1'b1;
    end else if (out_ready) begin
      ovld_nxt = 1'b0;
    end else begin
      ovld_nxt = ovld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign out_valid = ovld_r;

endmodule

[rtl/core/rme_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_checker
// Port level checks of the roman numeral encoder, bound to the top level.
// ----------------------------------------------------------------------------
module rme_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rme_pkg::SYM_W-1:0]   out_symbol,
  input logic                        out_last,
  input logic                        out_out_of_range
);
  import rme_pkg::*;

  // output register empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // one value in flight: busy right after an input transaction
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while busy");

  // error transaction stands alone with a null symbol
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (out_last && out_symbol == SYM_NONE))
    else $error("malformed out of range transaction");

  // regular transactions carry a roman letter
  a_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |->
      (out_symbol == 8'h49 || out_symbol == 8'h56 || out_symbol == 8'h58 ||
       out_symbol == 8'h4C || out_symbol == 8'h43 || out_symbol == 8'h44 ||
       out_symbol == 8'h4D))
    else $error("symbol is not a roman letter");

  // stalled output holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_symbol) && $stable(out_last) &&
       $stable(out_out_of_range)))
    else $error("output changed while stalled");

endmodule

bind roman_numeral_encoder rme_checker u_rme_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_symbol       (out_symbol),
  .out_last         (out_last),
  .out_out_of_range (out_out_of_range)
);

[tb/roman_numeral_encoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_numeral_encoder_tb
// Self-checking bench for the Roman numeral encoder. Signed values go in
// through the input handshake. A behavioral model spells the numeral of each
// accepted value, and every output transaction is compared with the oldest
// predicted character. Both handshakes idle at random, with one long stretch
// where they do not idle at all.
// ----------------------------------------------------------------------------
module roman_numeral_encoder_tb;
  import rme_pkg::VALUE_W;
  import rme_pkg::SYM_W;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 24;
  localparam int IDLE_PCT     = 13;
  localparam int MAX_MAG      = 3999;
  localparam int VALUE_SPAN   = 1 << VALUE_W;

  // numeral characters
  localparam logic [SYM_W-1:0] CH_NONE = 8'h00;
  localparam logic [SYM_W-1:0] CH_I    = "I";
  localparam logic [SYM_W-1:0] CH_V    = "V";
  localparam logic [SYM_W-1:0] CH_X    = "X";
  localparam logic [SYM_W-1:0] CH_L    = "L";
  localparam logic [SYM_W-1:0] CH_C    = "C";
  localparam logic [SYM_W-1:0] CH_D    = "D";
  localparam logic [SYM_W-1:0] CH_M    = "M";

  // per decimal place: ones, tens, hundreds, thousands
  localparam logic [SYM_W-1:0] ONE_CH  [4] = '{CH_I, CH_X, CH_C, CH_M};
  localparam logic [SYM_W-1:0] FIVE_CH [4] = '{CH_V, CH_L, CH_D, CH_NONE};
  localparam logic [SYM_W-1:0] TEN_CH  [4] = '{CH_X, CH_C, CH_M, CH_NONE};
  localparam int               WEIGHT  [4] = '{1, 10, 100, 1000};

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             oor;
  } roman_char_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SYM_W-1:0]   out_symbol;
  logic               out_last;
  logic               out_out_of_range;

  roman_char_t pending_chars[$];
  int          mismatches = 0;
  int          cycle_count = 0;
  bit          calm = 1'b0;

  roman_numeral_encoder DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_symbol       (out_symbol),
    .out_last         (out_last),
    .out_out_of_range (out_out_of_range)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("roman_numeral_encoder regression: fail");
      $finish;
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // spell the numeral of one value and queue its characters
  function automatic void spell_numeral(input logic [VALUE_W-1:0] v);
    int          mag;
    int          dig;
    roman_char_t ch;
    roman_char_t word[$];
    mag = v[VALUE_W-1] ? VALUE_SPAN - int'(v) : int'(v);
    ch.last = 1'b0;
    ch.oor  = 1'b0;
    // out of range: one flagged transaction
    if (mag > MAX_MAG) begin
      ch.symbol = CH_NONE;
      ch.last   = 1'b1;
      ch.oor    = 1'b1;
      pending_chars.push_back(ch);
      return;
    end
    for (int p = 3; p >= 0; p--) begin
      dig = (mag / WEIGHT[p]) % 10;
      if (dig == 4 || dig == 9) begin
        ch.symbol = ONE_CH[p];
        word.push_back(ch);
        ch.symbol = (dig == 4) ? FIVE_CH[p] : TEN_CH[p];
        word.push_back(ch);
      end else begin
        if (dig >= 5) begin
          ch.symbol = FIVE_CH[p];
          word.push_back(ch);
        end
        ch.symbol = ONE_CH[p];
        for (int r = 0; r < dig % 5; r++) begin
          word.push_back(ch);
        end
      end
    end
    // zero magnitude gives nothing
    if (word.size() != 0) begin
      word[word.size() - 1].last = 1'b1;
    end
    foreach (word[i]) begin
      pending_chars.push_back(word[i]);
    end
  endfunction

  // output transaction check
  always @(posedge clk) begin
    roman_char_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected transaction: symbol %h last %b out_of_range %b",
               out_symbol, out_last, out_out_of_range);
        mismatches = mismatches + 1;
      end else begin
        want = pending_chars.pop_front();
        if (out_symbol !== want.symbol) begin
          $error("symbol: expected %h actual %h", want.symbol, out_symbol);
          mismatches = mismatches + 1;
        end
        if (out_last !== want.last) begin
          $error("last: expected %b actual %b", want.last, out_last);
          mismatches = mismatches + 1;
        end
        if (out_out_of_range !== want.oor) begin
          $error("out_of_range: expected %b actual %b", want.oor, out_out_of_range);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  // one input transaction, with an occasional idle gap ahead of it
  task automatic send_value(input logic [VALUE_W-1:0] v);
    if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    spell_numeral(v);
  endtask

  task automatic send_int(input int n);
    send_value(VALUE_W'(n));
  endtask

  // random value, weighted toward well-formed numerals
  function automatic logic [VALUE_W-1:0] random_value();
    int pick;
    int mag;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      mag = $urandom_range(1, MAX_MAG);
    end else if (pick < 75) begin
      mag = $urandom_range(1, 20);
    end else if (pick < 80) begin
      mag = 0;
    end else if (pick < 90) begin
      mag = $urandom_range(MAX_MAG + 1, VALUE_SPAN / 2 - 1);
    end else begin
      return VALUE_W'($urandom);
    end
    return ($urandom_range(0, 1) == 1) ? VALUE_W'(-mag) : VALUE_W'(mag);
  endfunction

  // zero, range edges, most negative pattern, longest numeral
  task automatic test_range_limits();
    send_int(0);
    send_int(1);
    send_int(-1);
    send_int(3999);
    send_int(-3999);
    send_int(4000);
    send_int(-4000);
    send_int(8191);
    send_int(-8191);
    send_value({1'b1, {(VALUE_W-1){1'b0}}});
    send_int(3888);
    send_int(-3888);
  endtask

  // every digit form at the ones, tens and hundreds places: units, four, five-plus, nine
  task automatic test_digit_forms();
    send_int(3694);
    send_int(2471);
    send_int(1925);
    send_int(-1038);
    send_int(2760);
    send_int(3582);
    send_int(-1209);
    send_int(444);
    send_int(999);
    send_int(-1557);
    send_int(3);
    send_int(-7);
  endtask

  // random values with idling on both sides
  task automatic test_random_mix();
    repeat (120) send_value(random_value());
  endtask

  // random values with no idling at all
  task automatic test_back_to_back();
    calm = 1'b1;
    repeat (80) send_value(random_value());
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_range_limits();
    test_digit_forms();
    test_random_mix();
    test_back_to_back();

    // drain
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("roman_numeral_encoder regression: pass");
    end else begin
      $display("roman_numeral_encoder regression: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rme_pkg.sv
rtl/core/rme_datapath.sv
rtl/core/rme_ctrl.sv
rtl/core/roman_numeral_encoder.sv
rtl/core/rme_checker.sv
tb/roman_numeral_encoder_tb.sv
